/* design/elpe_pkg.sv */
// ---------------------------------------------------------------------------
// elpe_pkg
// shared constants and types for the exclusive lasso prox engine
// ---------------------------------------------------------------------------
package elpe_pkg;
    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int GROUP_COUNT_DEF  = 16;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int DATA_W  = 32;
    localparam int GID_W   = 4;
    localparam int NORM_W  = 38;
    localparam int SWEEP_W = 10;
    localparam int SCALE_W = 17;
    localparam int IDX_W   = 6;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_LAMBDA = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHRINK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEPS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX    = 3'd4;

    localparam logic [SWEEP_W-1:0] SWEEPS_RESET = 10'd100;

    typedef struct packed {
        logic [DATA_W-1:0]  lambda;
        logic [SCALE_W-1:0] shrink_scale;
        logic [DATA_W-1:0]  conv_thresh_sq;
        logic [SWEEP_W-1:0] max_sweeps;
        logic               box_enable;
    } t_cfg;
endpackage

/* design/elpe_ram.sv */
// ---------------------------------------------------------------------------
// elpe_ram
// generic single write port ram with registered read
// ---------------------------------------------------------------------------
module elpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* design/elpe_cfg_regs.sv */
// ---------------------------------------------------------------------------
// elpe_cfg_regs
// configuration register bank
// ---------------------------------------------------------------------------
module elpe_cfg_regs
    import elpe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_wdata,
    output t_cfg                 o_cfg
);
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lambda         <= '0;
            r_cfg.shrink_scale   <= SCALE_W'(65536);
            r_cfg.conv_thresh_sq <= DATA_W'(1);
            r_cfg.max_sweeps     <= SWEEPS_RESET;
            r_cfg.box_enable     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LAMBDA: r_cfg.lambda         <= i_cfg_wdata;
                REG_SHRINK: r_cfg.shrink_scale   <= i_cfg_wdata[SCALE_W-1:0];
                REG_THRESH: r_cfg.conv_thresh_sq <= i_cfg_wdata;
                REG_SWEEPS: r_cfg.max_sweeps     <= i_cfg_wdata[SWEEP_W-1:0];
                REG_BOX:    r_cfg.box_enable     <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

/* design/exclusive_lasso_prox_engine_top.sv */
// ---------------------------------------------------------------------------
// exclusive_lasso_prox_engine_top
// exclusive lasso prox: gauss-seidel sweeps per group on one shared multiplier
// load: one element per cycle; after the last one each group scans all n stored
//   elements, then, when not empty, runs its sweeps over the m members
// output: results in element order, held under receiver stalls; input not ready from
//   the last element until the final result is taken
// reset: synchronous active low, clears control state and config registers
// ---------------------------------------------------------------------------
module exclusive_lasso_prox_engine_top
    import elpe_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int GROUP_COUNT  = GROUP_COUNT_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // z_value[31:0], group_id[35:32], lower_limit[67:36], upper_limit[99:68]
    input  logic [103:0]         s_axis_tdata,
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // coefficient[31:0], element_index[37:32]
    output logic [39:0]          m_axis_tdata,
    output logic                 m_axis_tlast,
    // limit_hit
    output logic                 m_axis_tuser,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_wdata
);
    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int MW = 2 * DATA_W;
    localparam int VW = DATA_W + 2;

    localparam logic [MW-1:0] MAG_CAP = MW'(1) << (DATA_W - 1);
    localparam logic [MW-1:0] POS_MAX = MAG_CAP - MW'(1);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;   // read element, check group
    localparam logic [3:0] S_INITW = 4'd2;
    localparam logic [3:0] S_SWP   = 4'd3;   // fetch next member
    localparam logic [3:0] S_SWPW  = 4'd4;
    localparam logic [3:0] S_TH0   = 4'd5;   // lambda*rest lo
    localparam logic [3:0] S_TH1   = 4'd6;   // lambda*rest hi
    localparam logic [3:0] S_SUB   = 4'd7;   // soft threshold
    localparam logic [3:0] S_SCL   = 4'd8;   // (m-t)*scale
    localparam logic [3:0] S_UPD   = 4'd9;   // clamp, write back
    localparam logic [3:0] S_DIF   = 4'd10;  // norm and change
    localparam logic [3:0] S_SQ    = 4'd11;  // d*d
    localparam logic [3:0] S_ENDS  = 4'd12;  // end of sweep
    localparam logic [3:0] S_NEXTG = 4'd13;
    localparam logic [3:0] S_OUTR  = 4'd14;
    localparam logic [3:0] S_OUT   = 4'd15;

    t_cfg w_cfg;
    elpe_cfg_regs u_cfg (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_wdata, .o_cfg(w_cfg)
    );

    logic [3:0]         r_state;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_idx;
    logic [GW-1:0]      r_grp;
    logic [NORM_W-1:0]  r_norm;
    logic [NORM_W-1:0]  r_rest;
    logic [SWEEP_W-1:0] r_sweeps;
    logic [MW-1:0]      r_change;
    logic               r_any;
    logic               r_hit;
    logic [MW-1:0]      r_t;
    logic [DATA_W-1:0]  r_m;
    logic [MW-1:0]      r_prod;
    logic [DATA_W-1:0]  r_old;
    logic [DATA_W-1:0]  r_new;
    logic [DATA_W-1:0]  r_d;

    // memories
    logic              w_ld_we;
    logic [AW-1:0]     w_raddr;
    logic [DATA_W-1:0] w_z, w_lo, w_up, w_beta;
    logic [GID_W-1:0]  w_gid;
    logic              w_bwe;
    logic [AW-1:0]     w_baddr;
    logic [DATA_W-1:0] w_bdata;

    assign s_axis_tready = (r_state == S_LOAD);
    assign w_ld_we = s_axis_tvalid && s_axis_tready && (r_count < CW'(MAX_ELEMENTS));

    elpe_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS)) u_z (
        .i_clk, .i_we(w_ld_we), .i_waddr(r_count[AW-1:0]),
        .i_wdata(s_axis_tdata[31:0]), .i_raddr(w_raddr), .o_rdata(w_z));
    elpe_ram #(.WIDTH(GID_W), .DEPTH(MAX_ELEMENTS)) u_g (
        .i_clk, .i_we(w_ld_we), .i_waddr(r_count[AW-1:0]),
        .i_wdata(s_axis_tdata[35:32]), .i_raddr(w_raddr), .o_rdata(w_gid));
    elpe_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS)) u_lo (
        .i_clk, .i_we(w_ld_we), .i_waddr(r_count[AW-1:0]),
        .i_wdata(s_axis_tdata[67:36]), .i_raddr(w_raddr), .o_rdata(w_lo));
    elpe_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS)) u_up (
        .i_clk, .i_we(w_ld_we), .i_waddr(r_count[AW-1:0]),
        .i_wdata(s_axis_tdata[99:68]), .i_raddr(w_raddr), .o_rdata(w_up));
    elpe_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS)) u_beta (
        .i_clk, .i_we(w_bwe), .i_waddr(w_baddr),
        .i_wdata(w_bdata), .i_raddr(w_raddr), .o_rdata(w_beta));

    assign w_raddr = r_idx;
    assign w_baddr = r_idx;

    // group of the element just read, clipped into range
    logic [GW-1:0] w_elem_grp;
    always_comb begin
        if (7'(w_gid) >= 7'(GROUP_COUNT)) w_elem_grp = GW'(GROUP_COUNT - 1);
        else                               w_elem_grp = GW'(w_gid);
    end

    logic w_member;
    assign w_member = (w_elem_grp == r_grp);

    logic w_last_idx;
    assign w_last_idx = (CW'(r_idx) + CW'(1) == r_count);

    // shared multiplier, one product per cycle
    logic [DATA_W-1:0] w_ma;
    logic [DATA_W-1:0] w_mb;
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_TH0: begin
                w_ma = w_cfg.lambda;
                w_mb = r_rest[DATA_W-1:0];
            end
            S_TH1: begin
                w_ma = w_cfg.lambda;
                w_mb = DATA_W'(r_rest[NORM_W-1:DATA_W]);
            end
            S_SCL: begin
                w_ma = r_m;
                w_mb = DATA_W'(w_cfg.shrink_scale);
            end
            S_SQ: begin
                w_ma = r_d;
                w_mb = r_d;
            end
            default: ;
        endcase
    end
    logic [MW-1:0] w_mul;
    assign w_mul = MW'(w_ma) * MW'(w_mb);

    // magnitudes
    logic [DATA_W-1:0] w_zmag, w_bmag, w_nmag;
    assign w_zmag = w_z[DATA_W-1]    ? -w_z    : w_z;
    assign w_bmag = w_beta[DATA_W-1] ? -w_beta : w_beta;
    assign w_nmag = r_new[DATA_W-1]  ? -r_new  : r_new;

    // scaled magnitude to signed value, then box clamps when enabled
    logic [MW-1:0]        w_r;
    logic signed [VW-1:0] w_v, w_vc, w_los, w_ups;
    assign w_los = VW'($signed(w_lo));
    assign w_ups = VW'($signed(w_up));
    always_comb begin
        w_r = r_prod >> FRAC_BITS;
        if (w_r > MAG_CAP) w_r = MAG_CAP;
        if (w_z[DATA_W-1]) w_v = -$signed({1'b0, w_r[DATA_W:0]});
        else if (w_r > POS_MAX) w_v = $signed({2'b0, POS_MAX[DATA_W-1:0]});
        else w_v = $signed({1'b0, w_r[DATA_W:0]});
        w_vc = w_v;
        if (w_cfg.box_enable) begin
            if (w_vc < w_los) w_vc = w_los;
            if (w_vc > w_ups) w_vc = w_ups;
        end
    end

    logic signed [DATA_W:0] w_diff;
    assign w_diff = (DATA_W+1)'($signed(r_new)) - (DATA_W+1)'($signed(r_old));

    logic [SWEEP_W-1:0] w_limit;
    logic [SWEEP_W-1:0] w_sweeps_nx;
    assign w_limit     = (w_cfg.max_sweeps == '0) ? SWEEP_W'(1) : w_cfg.max_sweeps;
    assign w_sweeps_nx = r_sweeps + SWEEP_W'(1);

    assign w_bwe   = (r_state == S_INITW && w_member) || (r_state == S_UPD);
    assign w_bdata = (r_state == S_UPD) ? w_vc[DATA_W-1:0] : w_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_idx    <= '0;
            r_grp    <= '0;
            r_norm   <= '0;
            r_rest   <= '0;
            r_sweeps <= '0;
            r_change <= '0;
            r_any    <= 1'b0;
            r_hit    <= 1'b0;
            r_t      <= '0;
            r_m      <= '0;
            r_prod   <= '0;
            r_old    <= '0;
            r_new    <= '0;
            r_d      <= '0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (s_axis_tvalid) begin
                        if (w_ld_we) r_count <= r_count + CW'(1);
                        if (s_axis_tlast) begin
                            r_idx   <= '0;
                            r_grp   <= '0;
                            r_hit   <= 1'b0;
                            r_norm  <= '0;
                            r_any   <= 1'b0;
                            r_state <= S_INIT;
                        end
                    end
                end
                S_INIT: r_state <= S_INITW;
                S_INITW: begin
                    if (w_member) begin
                        r_norm <= r_norm + NORM_W'(w_zmag);
                        r_any  <= 1'b1;
                    end
                    if (w_last_idx) begin
                        r_idx    <= '0;
                        r_sweeps <= '0;
                        r_change <= '0;
                        r_state  <= (r_any || w_member) ? S_SWP : S_NEXTG;
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= S_INIT;
                    end
                end
                S_SWP: r_state <= S_SWPW;
                S_SWPW: begin
                    if (w_member) begin
                        r_old   <= w_beta;
                        r_rest  <= r_norm - NORM_W'(w_bmag);
                        r_state <= S_TH0;
                    end else if (w_last_idx) begin
                        r_state <= S_ENDS;
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= S_SWP;
                    end
                end
                S_TH0: begin
                    r_t     <= w_mul >> FRAC_BITS;
                    r_state <= S_TH1;
                end
                S_TH1: begin
                    r_t     <= r_t + (w_mul << (DATA_W - FRAC_BITS));
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    if (MW'(w_zmag) > r_t) r_m <= w_zmag - r_t[DATA_W-1:0];
                    else r_m <= '0;
                    r_state <= S_SCL;
                end
                S_SCL: begin
                    r_prod  <= w_mul;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_new   <= w_vc[DATA_W-1:0];
                    r_state <= S_DIF;
                end
                S_DIF: begin
                    r_norm  <= r_rest + NORM_W'(w_nmag);
                    r_d     <= w_diff[DATA_W] ? DATA_W'(-w_diff) : w_diff[DATA_W-1:0];
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_change <= r_change + (w_mul >> FRAC_BITS);
                    if (w_last_idx) begin
                        r_state <= S_ENDS;
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= S_SWP;
                    end
                end
                S_ENDS: begin
                    if (r_change <= MW'(w_cfg.conv_thresh_sq)) begin
                        r_state <= S_NEXTG;
                    end else if (w_sweeps_nx >= w_limit) begin
                        r_hit   <= 1'b1;
                        r_state <= S_NEXTG;
                    end else begin
                        r_sweeps <= w_sweeps_nx;
                        r_change <= '0;
                        r_idx    <= '0;
                        r_state  <= S_SWP;
                    end
                end
                S_NEXTG: begin
                    r_idx  <= '0;
                    r_norm <= '0;
                    r_any  <= 1'b0;
                    if (r_grp == GW'(GROUP_COUNT - 1)) begin
                        r_state <= S_OUTR;
                    end else begin
                        r_grp   <= r_grp + GW'(1);
                        r_state <= S_INIT;
                    end
                end
                S_OUTR: r_state <= S_OUT;
                S_OUT: begin
                    if (m_axis_tready) begin
                        if (w_last_idx) begin
                            r_count <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_idx   <= r_idx + AW'(1);
                            r_state <= S_OUTR;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {2'b0, IDX_W'(r_idx), w_beta};
    assign m_axis_tlast  = w_last_idx;
    assign m_axis_tuser  = r_hit;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid);
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser));
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid));
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ELEMENTS));
endmodule

/* verif/elpe_checker.sv */
// ---------------------------------------------------------------------------
// elpe_checker
// watches the load, result and register channels of the prox engine, works
// out the coefficients of each run itself and compares every result
// ---------------------------------------------------------------------------
module elpe_checker
    import elpe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [103:0]         i_s_tdata,
    input  logic                 i_s_tlast,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [39:0]          i_m_tdata,
    input  logic                 i_m_tlast,
    input  logic                 i_m_tuser,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_wdata,
    output int                   o_fail_count,
    output int                   o_pending
);
    typedef struct packed {
        logic [DATA_W-1:0] coef;
        logic [IDX_W-1:0]  idx;
        logic              last;
        logic              hit;
    } t_coef;

    t_cfg                     cfg;
    logic signed [DATA_W-1:0] z_mem   [MAX_ELEMENTS_DEF];
    logic [GID_W-1:0]         gid_mem [MAX_ELEMENTS_DEF];
    logic signed [DATA_W-1:0] lo_mem  [MAX_ELEMENTS_DEF];
    logic signed [DATA_W-1:0] up_mem  [MAX_ELEMENTS_DEF];
    logic signed [DATA_W-1:0] beta    [MAX_ELEMENTS_DEF];
    int                       loaded;
    t_coef                    coef_q[$];
    int                       fails;

    assign o_fail_count = fails;
    assign o_pending    = coef_q.size();

    function automatic logic [63:0] abs64(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] penalty_level(logic [63:0] rest);
        logic [63:0] lam;
        lam = 64'(cfg.lambda);
        return ((lam * (rest >> 32)) << (32 - FRAC_BITS_DEF)) +
               ((lam * {32'd0, rest[31:0]}) >> FRAC_BITS_DEF);
    endfunction

    function automatic longint shrink_element(int k, logic [63:0] t);
        longint      z;
        longint      v;
        logic [63:0] m;
        logic [63:0] r;
        z = z_mem[k];
        m = abs64(z);
        if (m <= t) r = 0;
        else r = ((m - t) * 64'(cfg.shrink_scale)) >> FRAC_BITS_DEF;
        if (r > 64'h8000_0000) r = 64'h8000_0000;
        if (z < 0) v = -longint'(r);
        else v = (r > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : longint'(r);
        if (cfg.box_enable) begin
            if (v < longint'(lo_mem[k])) v = lo_mem[k];
            if (v > longint'(up_mem[k])) v = up_mem[k];
        end
        return v;
    endfunction

    function automatic bit solve_group(int g, int n);
        int          sweeps;
        int          cap;
        logic [63:0] norm;
        logic [63:0] rest;
        logic [63:0] change;
        logic [63:0] d;
        longint      prev;
        longint      nb;
        bit          any;
        sweeps = 0;
        cap = (cfg.max_sweeps == 0) ? 1 : int'(cfg.max_sweeps);
        norm = 0;
        any = 0;
        for (int k = 0; k < n; k++) begin
            if (gid_mem[k] == g) begin
                beta[k] = z_mem[k];
                norm += abs64(longint'(z_mem[k]));
                any = 1;
            end
        end
        if (!any) return 0;
        forever begin
            change = 0;
            for (int k = 0; k < n; k++) begin
                if (gid_mem[k] != g) continue;
                prev = beta[k];
                rest = norm - abs64(prev);
                nb = shrink_element(k, penalty_level(rest));
                norm = rest + abs64(nb);
                beta[k] = nb[31:0];
                d = abs64(nb - prev);
                change += (d * d) >> FRAC_BITS_DEF;
            end
            sweeps++;
            if (change <= 64'(cfg.conv_thresh_sq)) return 0;
            if (sweeps >= cap) return 1;
        end
    endfunction

    task automatic predict_run();
        bit    hit;
        t_coef c;
        hit = 0;
        for (int g = 0; g < GROUP_COUNT_DEF; g++)
            if (solve_group(g, loaded)) hit = 1;
        for (int k = 0; k < loaded; k++) begin
            c.coef = beta[k];
            c.idx  = k[IDX_W-1:0];
            c.last = (k + 1 == loaded);
            c.hit  = hit;
            coef_q.push_back(c);
        end
        loaded = 0;
    endtask

    always @(posedge i_clk) begin
        t_coef want;
        if (!i_rst_n) begin
            cfg.lambda         <= '0;
            cfg.shrink_scale   <= 17'd65536;
            cfg.conv_thresh_sq <= 32'd1;
            cfg.max_sweeps     <= SWEEPS_RESET;
            cfg.box_enable     <= 1'b0;
            loaded = 0;
            fails  = 0;
            coef_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_LAMBDA: cfg.lambda         <= i_cfg_wdata;
                    REG_SHRINK: cfg.shrink_scale   <= i_cfg_wdata[SCALE_W-1:0];
                    REG_THRESH: cfg.conv_thresh_sq <= i_cfg_wdata;
                    REG_SWEEPS: cfg.max_sweeps     <= i_cfg_wdata[SWEEP_W-1:0];
                    REG_BOX:    cfg.box_enable     <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                if (loaded < MAX_ELEMENTS_DEF) begin
                    z_mem[loaded]   = i_s_tdata[31:0];
                    gid_mem[loaded] = i_s_tdata[35:32];
                    lo_mem[loaded]  = i_s_tdata[67:36];
                    up_mem[loaded]  = i_s_tdata[99:68];
                    loaded++;
                end
                if (i_s_tlast) predict_run();
            end
            if (i_m_tvalid && i_m_tready) begin
                if (coef_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result transaction: data %h last %b user %b",
                                 i_m_tdata, i_m_tlast, i_m_tuser);
                end else begin
                    want = coef_q.pop_front();
                    if (i_m_tdata[31:0] !== want.coef || i_m_tdata[37:32] !== want.idx ||
                        i_m_tlast !== want.last || i_m_tuser !== want.hit) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: expected coef %h idx %0d last %b hit %b, got coef %h idx %0d last %b hit %b",
                                     want.coef, want.idx, want.last, want.hit,
                                     i_m_tdata[31:0], i_m_tdata[37:32], i_m_tlast, i_m_tuser);
                    end
                end
            end
        end
    end
endmodule

/* verif/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// drives directed and random element vectors and register settings into the
// prox engine, mostly under random idling on both channels; the checker judges
// ---------------------------------------------------------------------------
module tb_top;
    import elpe_pkg::*;

    localparam int WATCHDOG_LIMIT = 600000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_valid;
    logic                 s_ready;
    logic [103:0]         s_data;
    logic                 s_last;
    logic                 m_valid;
    logic                 m_ready;
    logic [39:0]          m_data;
    logic                 m_last;
    logic                 m_user;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_wdata;
    int                   fail_count;
    int                   pending;
    int                   send_idle_pct;
    int                   recv_idle_pct;
    int                   quiet_cycles;

    exclusive_lasso_prox_engine_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tlast  (s_last),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tlast  (m_last),
        .m_axis_tuser  (m_user),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (cfg_wdata)
    );

    elpe_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_valid),
        .i_s_tready   (s_ready),
        .i_s_tdata    (s_data),
        .i_s_tlast    (s_last),
        .i_m_tvalid   (m_valid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_data),
        .i_m_tlast    (m_last),
        .i_m_tuser    (m_user),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_element(logic [31:0] z, logic [3:0] gid, logic [31:0] lo,
                                logic [31:0] up, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {4'd0, up, lo, gid, z};
        s_last  <= last;
        do @(posedge i_clk); while (!s_ready);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic program_regs(logic [31:0] lam, logic [31:0] shr, logic [31:0] thr,
                                logic [31:0] sw, logic [31:0] box);
        logic [31:0] vals [5];
        vals = '{lam, shr, thr, sw, box};
        for (int k = 0; k < 5; k++) begin
            cfg_we    <= 1'b1;
            cfg_index <= k[CFG_IDX_W-1:0];
            cfg_wdata <= vals[k];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_regs();
        logic [31:0] lam;
        logic [31:0] thr;
        case ($urandom_range(3))
            0: lam = 0;
            1: lam = $urandom_range(65536);
            2: lam = $urandom_range(8192);
            default: lam = $urandom;
        endcase
        case ($urandom_range(3))
            0: thr = 0;
            1: thr = $urandom_range(16);
            2: thr = $urandom_range(65536);
            default: thr = $urandom;
        endcase
        program_regs(lam, $urandom_range(65536), thr, $urandom_range(8, 1),
                     $urandom_range(1));
    endtask

    task automatic random_run(int n, int groups);
        logic [31:0] z;
        logic [31:0] a;
        logic [31:0] b;
        for (int k = 0; k < n; k++) begin
            z = $urandom;
            if ($urandom_range(3) == 0) z = $signed(z) >>> $urandom_range(16);
            a = $urandom;
            b = $urandom;
            if ($urandom_range(3) != 0 && $signed(a) > $signed(b)) {a, b} = {b, a};
            send_element(z, 4'($urandom_range(groups - 1)), a, b, k == n - 1);
        end
    endtask

    initial begin
        int n;
        i_rst_n       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        s_last        = 1'b0;
        m_ready       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        quiet_cycles  = 0;
        send_idle_pct = 31;
        recv_idle_pct = 47;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, field extremes, top group id
        send_element(32'h7FFF_FFFF, 4'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_element(32'h8000_0000, 4'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_element(32'h0000_0000, 4'd15, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        send_element(32'hFFFF_FFFF, 4'd15, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        settle();
        // box clamps with crossed bounds, sweep limit of zero, oversized scale
        program_regs(32'h0000_8000, 32'h1_FFFF, 32'd0, 32'd0, 32'd1);
        send_element(32'h0010_0000, 4'd2, 32'h0002_0000, 32'h0001_0000, 1'b0);
        send_element(32'h7FFF_FFFF, 4'd2, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_element(32'hFFF0_0000, 4'd3, 32'hFFFF_0000, 32'h0000_1000, 1'b0);
        send_element(32'h8000_0000, 4'd3, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        settle();
        // heavy penalty, non-settling groups, short sweep limit
        program_regs(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd0);
        send_element(32'h0003_0000, 4'd1, 32'd0, 32'd0, 1'b0);
        send_element(32'hFFFD_0000, 4'd1, 32'd0, 32'd0, 1'b1);
        settle();
        program_regs(32'h0000_4000, 32'd52429, 32'd0, 32'd3, 32'd0);
        send_element(32'h0005_0000, 4'd4, 32'd0, 32'd0, 1'b0);
        send_element(32'h0004_0000, 4'd4, 32'd0, 32'd0, 1'b0);
        send_element(32'hFFFA_0000, 4'd4, 32'd0, 32'd0, 1'b0);
        send_element(32'h0001_0000, 4'd5, 32'd0, 32'd0, 1'b1);
        settle();
        // longest sweep limit with a setting that settles at once
        program_regs(32'd0, 32'd65536, 32'd0, 32'd1023, 32'd0);
        send_element(32'h1234_5678, 4'd7, 32'd0, 32'd0, 1'b0);
        send_element(32'h8765_4321, 4'd7, 32'd0, 32'd0, 1'b1);
        settle();
        // vector full: two elements past the limit, the last still starts the run
        random_regs();
        random_run(66, 16);
        settle();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 47 : 0;
            recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 31 : 0;
            for (int r = 0; r < 9; r++) begin
                random_regs();
                n = ($urandom_range(7) == 0) ? $urandom_range(12, 5) : $urandom_range(3, 1);
                random_run(n, ($urandom_range(1) == 0) ? 3 : 16);
                settle();
            end
        end

        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
